// ===== hw/rtl/ising_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the Ising lattice Metropolis update block.
package ising_pkg;

   // Lattice geometry; SIDE is a power of two so that coordinates wrap by masking.
   localparam int SIDE       = 32;
   localparam int COORD_W    = $clog2(SIDE);
   localparam int SITES      = SIDE * SIDE;
   localparam int ADDR_W     = $clog2(SITES);

   // Field widths of the item and result beats.
   localparam int ACTION_W   = 2;
   localparam int POS_W      = 5;
   localparam int FRAC_W     = 12;
   localparam int PARAM_W    = 16;
   localparam int THR_W      = 12;
   localparam int THR_N      = 5;
   localparam int THR_WORD_W = THR_W * THR_N;
   localparam int DE_W       = 20;
   localparam int MAG_W      = 12;

   // Configuration port geometry: registers at byte address 8*i.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LO = 3;

   typedef enum logic [1:0] {
      REG_COUPLING = 2'd0,
      REG_FIELD    = 2'd1,
      REG_THR_UP   = 2'd2,
      REG_THR_DOWN = 2'd3
   } reg_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_PROPOSE = 2'd2
   } action_type;

endpackage

// ===== hw/rtl/ising_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for item and result beats.
interface ising_req_if;
   import ising_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [POS_W-1:0]    row;
   logic [POS_W-1:0]    col;
   logic                spin_value;
   logic [FRAC_W-1:0]   random_fraction;

   modport source (output valid, action, row, col, spin_value, random_fraction,
                   input ready);
   modport sink   (input valid, action, row, col, spin_value, random_fraction,
                   output ready);
endinterface

interface ising_rsp_if;
   import ising_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    spin;
   logic                    accepted;
   logic signed [DE_W-1:0]  energy_change;
   logic signed [MAG_W-1:0] magnetization;

   modport source (output valid, spin, accepted, energy_change, magnetization,
                   input ready);
   modport sink   (input valid, spin, accepted, energy_change, magnetization,
                   output ready);
endinterface

// ===== hw/rtl/ising_lattice_metropolis_update.sv =====
`timescale 1ns / 1ps
// Top level of the Ising lattice single-spin-flip Metropolis update block.
//
// Items arrive on req_ch: write a spin, read a spin, or propose flipping one
// site of the toroidal lattice. Every item gives exactly one result beat on
// rsp_ch with the site spin, the accept flag, the energy change and the
// magnetization after the item. Coupling, field and the two threshold words
// are written through the csr_ port; the user must write them only while the
// block is idle, as the block itself does not enforce it. The lattice
// lives in a one-bit RAM with one read and one write port. A read or write
// fetches only the center site; a proposal fetches the center and then its
// four neighbors through the single RAM read port. One item is processed at
// a time; the next item is accepted once the result is in the output
// register, even while that result waits. After reset the block zeros the
// lattice one site per cycle over all SIDE*SIDE (1024) sites; req_ch.ready
// stays low during that pass, while configuration writes are taken. When
// the receiver stalls, the finished result is held, and a following item
// waits before commit until the output register is free.
module ising_lattice_metropolis_update (
   input  logic                                clock,
   input  logic                                reset,
   ising_req_if.sink                           req_ch,
   ising_rsp_if.source                         rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ising_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ising_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ising_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import ising_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL
   } state_type;

   localparam logic [2:0] LAST_NB = 3'd4;

   // Control state.
   state_type               state_ff;
   logic [2:0]              rd_cnt_ff;
   logic                    clearing_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;

   // Latched item.
   logic [ACTION_W-1:0]     action_ff;
   logic [COORD_W-1:0]      row_ff;
   logic [COORD_W-1:0]      col_ff;
   logic                    wv_ff;
   logic [FRAC_W-1:0]       rnd_ff;
   logic                    center_ff;
   logic [3:0]              nb_ff;

   // Configuration and running sum.
   logic signed [PARAM_W-1:0] coupling_ff;
   logic signed [PARAM_W-1:0] field_ff;
   logic [THR_WORD_W-1:0]     thr_up_ff;
   logic [THR_WORD_W-1:0]     thr_down_ff;
   logic signed [MAG_W-1:0]   spin_sum_ff;
   logic signed [MAG_W-1:0]   spin_sum_in;

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_spin_ff;
   logic                    rsp_acc_ff;
   logic signed [DE_W-1:0]  rsp_de_ff;
   logic signed [MAG_W-1:0] rsp_mag_ff;

   // RAM ports.
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic                    ram_wdata;
   logic [ADDR_W-1:0]       ram_raddr;
   logic                    ram_rdata;

   // Evaluation signals.
   logic                    req_fire;
   logic                    out_free;
   logic                    commit;
   logic                    read_last;
   logic [2:0]              rd_next;
   logic [COORD_W-1:0]      req_row;
   logic [COORD_W-1:0]      req_col;
   logic                    new_spin;
   logic                    changed;
   logic                    acc;
   logic                    keep;
   logic                    flip_spin;
   logic [2:0]              agree;
   logic signed [DE_W-1:0]  j_ext;
   logic signed [DE_W-1:0]  b2_ext;
   logic signed [DE_W-1:0]  j_term;
   logic signed [DE_W-1:0]  de;
   logic signed [DE_W-1:0]  de_out;
   logic [THR_WORD_W-1:0]   thr_word;
   logic [THR_W-1:0]        thr;
   logic                    csr_wr;
   reg_index_type           csr_idx;

   function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
      return (v == COORD_W'(SIDE - 1)) ? '0 : COORD_W'(v + 1'b1);
   endfunction

   function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] v);
      return (v == '0) ? COORD_W'(SIDE - 1) : COORD_W'(v - 1'b1);
   endfunction

   function automatic logic [ADDR_W-1:0] site_addr(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c));
   endfunction

   // Read order: center, row below, row above, column right, column left.
   function automatic logic [ADDR_W-1:0] read_addr(input logic [2:0]         idx,
                                                   input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
      logic [ADDR_W-1:0] a;
      case (idx)
         3'd1:    a = site_addr(wrap_inc(r), c);
         3'd2:    a = site_addr(wrap_dec(r), c);
         3'd3:    a = site_addr(r, wrap_inc(c));
         3'd4:    a = site_addr(r, wrap_dec(c));
         default: a = site_addr(r, c);
      endcase
      return a;
   endfunction

   // Lattice storage.
   ising_ram #(
      .WIDTH (1),
      .DEPTH (SITES)
   ) u_lattice (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Handshakes and sequencing conditions.
   assign req_ch.ready = (state_ff == S_IDLE) && !clearing_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign commit       = (state_ff == S_EVAL) && out_free;
   assign req_row      = COORD_W'(req_ch.row % SIDE);
   assign req_col      = COORD_W'(req_ch.col % SIDE);
   assign rd_next      = rd_cnt_ff + 3'd1;
   assign read_last    = (action_ff == ACT_PROPOSE) ? (rd_cnt_ff == LAST_NB)
                                                    : (rd_cnt_ff == 3'd0);

   // Read address: center of the arriving item, else the next neighbor.
   always_comb begin
      if (state_ff == S_IDLE) begin
         ram_raddr = site_addr(req_row, req_col);
      end else begin
         ram_raddr = read_addr(rd_next, row_ff, col_ff);
      end
   end

   // Energy change of the proposed flip: 2J(2k-4) - 2B*s, with J and B in Q8.8.
   assign flip_spin = ~center_ff;
   assign agree     = 3'($countones(~(nb_ff ^ {4{flip_spin}})));
   assign j_ext     = DE_W'(coupling_ff);
   assign b2_ext    = DE_W'(field_ff) <<< 1;
   always_comb begin
      case (agree)
         3'd0:    j_term = -(j_ext <<< 3);
         3'd1:    j_term = -(j_ext <<< 2);
         3'd3:    j_term = j_ext <<< 2;
         3'd4:    j_term = j_ext <<< 3;
         default: j_term = '0;
      endcase
   end
   assign de       = j_term + (flip_spin ? -b2_ext : b2_ext);
   assign thr_word = flip_spin ? thr_up_ff : thr_down_ff;
   assign thr      = thr_word[THR_W*int'(agree) +: THR_W];
   assign keep     = (de <= 0) || (rnd_ff < thr);

   // Outcome of the item per action.
   always_comb begin
      new_spin = center_ff;
      changed  = 1'b0;
      acc      = 1'b0;
      de_out   = '0;
      case (action_ff)
         ACT_WRITE: begin
            new_spin = wv_ff;
            changed  = (wv_ff != center_ff);
         end
         ACT_PROPOSE: begin
            if (keep) begin
               new_spin = flip_spin;
               changed  = 1'b1;
               acc      = 1'b1;
               de_out   = de;
            end
         end
         default: begin
            new_spin = center_ff;
         end
      endcase
   end

   assign spin_sum_in = changed ? (spin_sum_ff + (new_spin ? MAG_W'(2) : -MAG_W'(2)))
                                : spin_sum_ff;

   // RAM write: the clearing pass after reset, then item commits.
   always_comb begin
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = 1'b0;
      end else begin
         ram_we    = commit && changed;
         ram_waddr = site_addr(row_ff, col_ff);
         ram_wdata = new_spin;
      end
   end

   // Configuration port decode.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_IDX_LO]);
   always_comb begin
      unique case (csr_idx)
         REG_COUPLING: csr_prdata = CSR_DATA_W'(unsigned'(coupling_ff));
         REG_FIELD:    csr_prdata = CSR_DATA_W'(unsigned'(field_ff));
         REG_THR_UP:   csr_prdata = CSR_DATA_W'(thr_up_ff);
         REG_THR_DOWN: csr_prdata = CSR_DATA_W'(thr_down_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= PARAM_W'(256);
         field_ff    <= '0;
         thr_up_ff   <= '0;
         thr_down_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_COUPLING: coupling_ff <= csr_pwdata[PARAM_W-1:0];
            REG_FIELD:    field_ff    <= csr_pwdata[PARAM_W-1:0];
            REG_THR_UP:   thr_up_ff   <= csr_pwdata[THR_WORD_W-1:0];
            REG_THR_DOWN: thr_down_ff <= csr_pwdata[THR_WORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clearing pass over the lattice after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= ADDR_W'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == ADDR_W'(SITES - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Item sequencer with the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         spin_sum_ff  <= MAG_W'(-SITES);
      end else begin
         // A commit in the same cycle refills the output register instead.
         if (rsp_valid_ff && rsp_ch.ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  action_ff <= req_ch.action;
                  row_ff    <= req_row;
                  col_ff    <= req_col;
                  wv_ff     <= req_ch.spin_value;
                  rnd_ff    <= req_ch.random_fraction;
                  rd_cnt_ff <= '0;
                  state_ff  <= S_READ;
               end
            end
            S_READ: begin
               // The RAM returns the site read in the previous cycle.
               if (rd_cnt_ff == 3'd0) begin
                  center_ff <= ram_rdata;
               end else begin
                  nb_ff[2'(rd_cnt_ff - 3'd1)] <= ram_rdata;
               end
               if (read_last) begin
                  state_ff <= S_EVAL;
               end else begin
                  rd_cnt_ff <= rd_next;
               end
            end
            S_EVAL: begin
               if (out_free) begin
                  spin_sum_ff  <= spin_sum_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_spin_ff  <= new_spin;
                  rsp_acc_ff   <= acc;
                  rsp_de_ff    <= de_out;
                  rsp_mag_ff   <= spin_sum_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result beat.
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.spin          = rsp_spin_ff;
   assign rsp_ch.accepted      = rsp_acc_ff;
   assign rsp_ch.energy_change = rsp_de_ff;
   assign rsp_ch.magnetization = rsp_mag_ff;

endmodule

// ===== hw/rtl/ising_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module ising_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
